/* hdl/assert_macros.svh */
// Assertion macros shared by the frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define RRFP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rrfp assertion failed");

// Checked at every edge, reset included.
`define RRFP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rrfp assertion failed");

`else

`define RRFP_ASSERT(lbl, clk, rst_n, prop)
`define RRFP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* hdl/rrfp_pkg.sv */
// Types and constants of the radio response frame parser.
package rrfp_pkg;

    localparam int BYTE_W  = 8;
    localparam int SIZE_W  = 16;
    localparam int KIND_W  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_DIR     = 4'd2,
        PH_CMD     = 4'd3,
        PH_SIZEHI  = 4'd4,
        PH_SIZELO  = 4'd5,
        PH_HSUMHI  = 4'd6,
        PH_HSUMLO  = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_PSUMHI  = 4'd9,
        PH_PSUMLO  = 4'd10
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        K_PAYLOAD = 4'd0,
        K_OK      = 4'd1,
        K_ACK     = 4'd2,
        K_NACK    = 4'd3,
        K_BADSYNC = 4'd4,
        K_BADDIR  = 4'd5,
        K_BADHDR  = 4'd6,
        K_TOOLONG = 4'd7,
        K_BADPAY  = 4'd8
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC_FIRST  = 3'd0,
        REG_SYNC_SECOND = 3'd1,
        REG_DIRECTION   = 3'd2,
        REG_ACK_CODE    = 3'd3,
        REG_NACK_CODE   = 3'd4,
        REG_PAY_LIMIT   = 3'd5
    } reg_idx_t;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd72;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd101;
    localparam logic [BYTE_W-1:0] DIRECTION_RST   = 8'd32;
    localparam logic [SIZE_W-1:0] ACK_CODE_RST    = 16'd2570;
    localparam logic [SIZE_W-1:0] NACK_CODE_RST   = 16'hFFFF;
    localparam logic [BYTE_W-1:0] PAY_LIMIT_RST   = 8'hFF;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [BYTE_W-1:0] direction;
        logic [SIZE_W-1:0] ack_code;
        logic [SIZE_W-1:0] nack_code;
        logic [BYTE_W-1:0] pay_limit;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] command_code;
    } result_t;

endpackage

/* hdl/rrfp_core.sv */
// Frame state machine and running Fletcher sums of the frame parser.
`include "assert_macros.svh"

module rrfp_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rrfp_pkg::cfg_t              cfg,
    input  logic                        byte_accept,
    input  logic [rrfp_pkg::BYTE_W-1:0] rx_byte,
    output logic                        res_valid,
    output rrfp_pkg::result_t           res
);
    import rrfp_pkg::*;

    phase_t            phase_reg,     phase_next;
    logic [BYTE_W-1:0] cmd_reg,       cmd_next;
    logic [SIZE_W-1:0] size_reg,      size_next;
    logic [BYTE_W-1:0] run_low_reg,   run_low_next;
    logic [BYTE_W-1:0] run_high_reg,  run_high_next;
    logic [BYTE_W-1:0] sum_upper_reg, sum_upper_next;
    logic [BYTE_W-1:0] bytes_left_reg, bytes_left_next;

    // one sum step on the current byte, and two for the header-sum chaining
    logic [BYTE_W-1:0] add_high, add_low;
    logic [BYTE_W-1:0] ch_high1, ch_low1, ch_high2, ch_low2;
    logic [BYTE_W-1:0] left_dec;
    logic              hsum_bad;

    assign add_high = run_high_reg + rx_byte;
    assign add_low  = run_low_reg + add_high;
    assign ch_high1 = run_high_reg + sum_upper_reg;
    assign ch_low1  = run_low_reg + ch_high1;
    assign ch_high2 = ch_high1 + rx_byte;
    assign ch_low2  = ch_low1 + ch_high2;
    assign left_dec = bytes_left_reg - 8'd1;
    assign hsum_bad = (sum_upper_reg != run_high_reg) || (rx_byte != run_low_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SYNC1;
            cmd_reg        <= '0;
            size_reg       <= '0;
            run_low_reg    <= '0;
            run_high_reg   <= '0;
            sum_upper_reg  <= '0;
            bytes_left_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            cmd_reg        <= cmd_next;
            size_reg       <= size_next;
            run_low_reg    <= run_low_next;
            run_high_reg   <= run_high_next;
            sum_upper_reg  <= sum_upper_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        cmd_next         = cmd_reg;
        size_next        = size_reg;
        run_low_next     = run_low_reg;
        run_high_next    = run_high_reg;
        sum_upper_next   = sum_upper_reg;
        bytes_left_next  = bytes_left_reg;
        res_valid        = 1'b0;
        res.kind         = K_PAYLOAD;
        res.payload_byte = '0;
        res.command_code = cmd_reg;

        if (byte_accept) begin
            case (phase_reg)
                PH_SYNC2: begin
                    if (rx_byte != cfg.sync_second) begin
                        phase_next       = PH_SYNC1;
                        res_valid        = 1'b1;
                        res.kind         = K_BADSYNC;
                        res.command_code = '0;
                    end else begin
                        phase_next = PH_DIR;
                    end
                end
                PH_DIR: begin
                    if (rx_byte != cfg.direction) begin
                        phase_next       = PH_SYNC1;
                        res_valid        = 1'b1;
                        res.kind         = K_BADDIR;
                        res.command_code = '0;
                    end else begin
                        // sums restart from zero on the direction byte
                        run_high_next = rx_byte;
                        run_low_next  = rx_byte;
                        phase_next    = PH_CMD;
                    end
                end
                PH_CMD: begin
                    cmd_next      = rx_byte;
                    run_high_next = add_high;
                    run_low_next  = add_low;
                    phase_next    = PH_SIZEHI;
                end
                PH_SIZEHI: begin
                    size_next     = {rx_byte, 8'd0};
                    run_high_next = add_high;
                    run_low_next  = add_low;
                    phase_next    = PH_SIZELO;
                end
                PH_SIZELO: begin
                    size_next     = {size_reg[SIZE_W-1:BYTE_W], rx_byte};
                    run_high_next = add_high;
                    run_low_next  = add_low;
                    phase_next    = PH_HSUMHI;
                end
                PH_HSUMHI: begin
                    sum_upper_next = rx_byte;
                    phase_next     = PH_HSUMLO;
                end
                PH_HSUMLO: begin
                    if (hsum_bad) begin
                        phase_next = PH_SYNC1;
                        res_valid  = 1'b1;
                        res.kind   = K_BADHDR;
                    end else if (size_reg == cfg.ack_code) begin
                        phase_next = PH_SYNC1;
                        res_valid  = 1'b1;
                        res.kind   = K_ACK;
                    end else if (size_reg == cfg.nack_code) begin
                        phase_next = PH_SYNC1;
                        res_valid  = 1'b1;
                        res.kind   = K_NACK;
                    end else if (size_reg > {8'd0, cfg.pay_limit}) begin
                        phase_next = PH_SYNC1;
                        res_valid  = 1'b1;
                        res.kind   = K_TOOLONG;
                    end else begin
                        run_high_next   = ch_high2;
                        run_low_next    = ch_low2;
                        bytes_left_next = size_reg[BYTE_W-1:0];
                        phase_next      = (size_reg[BYTE_W-1:0] == '0) ? PH_PSUMHI
                                                                         : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    run_high_next    = add_high;
                    run_low_next     = add_low;
                    bytes_left_next  = left_dec;
                    if (left_dec == '0) begin
                        phase_next = PH_PSUMHI;
                    end
                    res_valid        = 1'b1;
                    res.kind         = K_PAYLOAD;
                    res.payload_byte = rx_byte;
                end
                PH_PSUMHI: begin
                    sum_upper_next = rx_byte;
                    phase_next     = PH_PSUMLO;
                end
                PH_PSUMLO: begin
                    phase_next = PH_SYNC1;
                    res_valid  = 1'b1;
                    res.kind   = hsum_bad ? K_BADPAY : K_OK;
                end
                default: begin
                    phase_next = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

    `RRFP_ASSERT_ALWAYS(a_reset_hunts, aclk, !aresetn |=> phase_reg == PH_SYNC1)
    `RRFP_ASSERT(a_res_needs_byte, aclk, aresetn, res_valid |-> byte_accept)
    `RRFP_ASSERT(a_payload_left, aclk, aresetn, phase_reg == PH_PAYLOAD |-> bytes_left_reg != '0)
    `RRFP_ASSERT(a_payload_phase, aclk, aresetn, (res_valid && res.kind == K_PAYLOAD) |-> phase_reg == PH_PAYLOAD)
    `RRFP_ASSERT(a_sum_hold, aclk, aresetn, (phase_reg == PH_HSUMHI && byte_accept) |=> (phase_reg == PH_HSUMLO && $stable(run_low_reg) && $stable(run_high_reg)))

endmodule

/* hdl/radio_response_frame_parser.sv */
// Top level of the radio response frame parser: registers, byte stage and result register.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  s_       | s_valid s_ready s_rx_byte               | in
//  m_       | m_valid m_ready m_kind m_payload_byte   | out
//           | m_command_code                          |
//  cfg_     | cfg_valid cfg_ready cfg_index cfg_data  | in
//
//  One byte per cycle while s_ready is high; its result, if any, shows in the result register the next cycle.
//  s_ready drops only while a result is held and m_ready is low.
//  Synchronous active-low reset sets the register file to its defaults and the parser
//  hunting for the first sync byte. cfg_ready is always high.
`include "assert_macros.svh"

module radio_response_frame_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [rrfp_pkg::BYTE_W-1:0]     s_rx_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rrfp_pkg::KIND_W-1:0]     m_kind,
    output logic [rrfp_pkg::BYTE_W-1:0]     m_payload_byte,
    output logic [rrfp_pkg::BYTE_W-1:0]     m_command_code,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rrfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrfp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rrfp_pkg::*;

    cfg_t    cfg_reg;
    logic    s_accept;
    logic    res_valid;
    result_t res;
    logic    m_valid_reg;
    result_t m_res_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first  <= SYNC_FIRST_RST;
            cfg_reg.sync_second <= SYNC_SECOND_RST;
            cfg_reg.direction   <= DIRECTION_RST;
            cfg_reg.ack_code    <= ACK_CODE_RST;
            cfg_reg.nack_code   <= NACK_CODE_RST;
            cfg_reg.pay_limit   <= PAY_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SYNC_FIRST:  cfg_reg.sync_first  <= cfg_data[BYTE_W-1:0];
                REG_SYNC_SECOND: cfg_reg.sync_second <= cfg_data[BYTE_W-1:0];
                REG_DIRECTION:   cfg_reg.direction   <= cfg_data[BYTE_W-1:0];
                REG_ACK_CODE:    cfg_reg.ack_code    <= cfg_data;
                REG_NACK_CODE:   cfg_reg.nack_code   <= cfg_data;
                REG_PAY_LIMIT:   cfg_reg.pay_limit   <= cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    rrfp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .byte_accept (s_accept),
        .rx_byte     (s_rx_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_res_reg.kind;
    assign m_payload_byte = m_res_reg.payload_byte;
    assign m_command_code = m_res_reg.command_code;

    `RRFP_ASSERT(a_no_overwrite, aclk, aresetn, (m_valid_reg && !m_ready) |-> !s_accept)
    `RRFP_ASSERT(a_result_lands, aclk, aresetn, (s_accept && res_valid) |=> m_valid_reg)
    `RRFP_ASSERT(a_silent_byte, aclk, aresetn, (s_accept && !res_valid) |=> !m_valid_reg)

endmodule

/* test/tb.sv */
// Self-checking bench for the radio response frame parser: framed byte streams against a parser model.
`timescale 1ns / 100ps

module tb;
    import rrfp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int SETTLE = 4;
    localparam int PHASE_BYTES = 60;

    typedef enum {FR_CLEAN, FR_NOISE, FR_SYNC, FR_DIR, FR_HDR, FR_PAY} fault_t;

    typedef struct {
        fault_t            fault;
        logic [BYTE_W-1:0] cmd;
        logic [SIZE_W-1:0] len;
        bit                typed;
        kind_t             kind;
        logic [BYTE_W-1:0] kind_cmd;
    } probe_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_rx_byte;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [KIND_W-1:0]     m_kind;
    logic [BYTE_W-1:0]     m_payload_byte;
    logic [BYTE_W-1:0]     m_command_code;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // parser model state and its copy of the registers
    cfg_t              cur_cfg;
    phase_t            cur_phase;
    logic [BYTE_W-1:0] held_cmd;
    logic [SIZE_W-1:0] held_len;
    logic [15:0]       run_sum;
    logic [BYTE_W-1:0] rx_sum_hi;
    logic [BYTE_W-1:0] remain;

    result_t           parser_out_q[$];
    logic [BYTE_W-1:0] frame_bytes[$];
    bit                calm = 1'b0;
    bit                row_typed = 1'b0;
    kind_t             row_kind;
    logic [BYTE_W-1:0] row_cmd;
    int                fails = 0;

    always #5 aclk = ~aclk;

    radio_response_frame_parser DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_payload_byte (m_payload_byte),
        .m_command_code (m_command_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // {sum1, sum2}, both mod 256
    function automatic logic [15:0] fletcher_step(input logic [15:0] s, input logic [7:0] b);
        logic [7:0] hi;
        hi = s[15:8] + b;
        return {hi, s[7:0] + hi};
    endfunction

    function automatic bit parse_byte(input logic [BYTE_W-1:0] b, output result_t r);
        r = '0;
        case (cur_phase)
            PH_SYNC2: begin
                if (b != cur_cfg.sync_second) begin
                    cur_phase = PH_SYNC1;
                    r.kind = K_BADSYNC;
                    return 1'b1;
                end
                cur_phase = PH_DIR;
            end
            PH_DIR: begin
                if (b != cur_cfg.direction) begin
                    cur_phase = PH_SYNC1;
                    r.kind = K_BADDIR;
                    return 1'b1;
                end
                run_sum = fletcher_step(16'h0000, b);
                cur_phase = PH_CMD;
            end
            PH_CMD: begin
                held_cmd = b;
                run_sum = fletcher_step(run_sum, b);
                cur_phase = PH_SIZEHI;
            end
            PH_SIZEHI: begin
                held_len = {b, 8'h00};
                run_sum = fletcher_step(run_sum, b);
                cur_phase = PH_SIZELO;
            end
            PH_SIZELO: begin
                held_len[7:0] = b;
                run_sum = fletcher_step(run_sum, b);
                cur_phase = PH_HSUMHI;
            end
            PH_HSUMHI: begin
                rx_sum_hi = b;
                cur_phase = PH_HSUMLO;
            end
            PH_HSUMLO: begin
                r.command_code = held_cmd;
                if ({rx_sum_hi, b} != run_sum) r.kind = K_BADHDR;
                else if (held_len == cur_cfg.ack_code) r.kind = K_ACK;
                else if (held_len == cur_cfg.nack_code) r.kind = K_NACK;
                else if (held_len > {8'h00, cur_cfg.pay_limit}) r.kind = K_TOOLONG;
                else begin
                    run_sum = fletcher_step(fletcher_step(run_sum, rx_sum_hi), b);
                    remain = held_len[7:0];
                    cur_phase = (remain == 8'h00) ? PH_PSUMHI : PH_PAYLOAD;
                    return 1'b0;
                end
                cur_phase = PH_SYNC1;
                return 1'b1;
            end
            PH_PAYLOAD: begin
                run_sum = fletcher_step(run_sum, b);
                remain = remain - 8'd1;
                if (remain == 8'h00) cur_phase = PH_PSUMHI;
                r = '{K_PAYLOAD, b, held_cmd};
                return 1'b1;
            end
            PH_PSUMHI: begin
                rx_sum_hi = b;
                cur_phase = PH_PSUMLO;
            end
            PH_PSUMLO: begin
                cur_phase = PH_SYNC1;
                r.kind = ({rx_sum_hi, b} != run_sum) ? K_BADPAY : K_OK;
                r.command_code = held_cmd;
                return 1'b1;
            end
            default: cur_phase = (b == cur_cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
        endcase
        return 1'b0;
    endfunction

    // frame_bytes receives one frame for the current registers, damaged as asked
    function automatic void build_frame(input fault_t f, input logic [BYTE_W-1:0] cmd,
                                        input logic [SIZE_W-1:0] len);
        logic [15:0] s;
        logic [15:0] hs;
        logic [7:0]  b;
        frame_bytes.delete();
        if (f == FR_NOISE) begin
            frame_bytes.push_back(cur_cfg.sync_first ^ 8'($urandom_range(1, 255)));
            return;
        end
        frame_bytes.push_back(cur_cfg.sync_first);
        if (f == FR_SYNC) begin
            frame_bytes.push_back(cur_cfg.sync_second ^ 8'($urandom_range(1, 255)));
            return;
        end
        frame_bytes.push_back(cur_cfg.sync_second);
        if (f == FR_DIR) begin
            frame_bytes.push_back(cur_cfg.direction ^ 8'($urandom_range(1, 255)));
            return;
        end
        frame_bytes.push_back(cur_cfg.direction);
        frame_bytes.push_back(cmd);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        s = fletcher_step(fletcher_step(fletcher_step(fletcher_step(16'h0000,
                cur_cfg.direction), cmd), len[15:8]), len[7:0]);
        hs = s;
        if (f == FR_HDR) hs = hs ^ 16'($urandom_range(1, 65535));
        frame_bytes.push_back(hs[15:8]);
        frame_bytes.push_back(hs[7:0]);
        if (f == FR_HDR || len == cur_cfg.ack_code || len == cur_cfg.nack_code ||
            len > {8'h00, cur_cfg.pay_limit})
            return;
        s = fletcher_step(fletcher_step(s, hs[15:8]), hs[7:0]);
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            frame_bytes.push_back(b);
            s = fletcher_step(s, b);
        end
        if (f == FR_PAY) s = s ^ 16'($urandom_range(1, 65535));
        frame_bytes.push_back(s[15:8]);
        frame_bytes.push_back(s[7:0]);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_len();
        int         r;
        logic [7:0] lim;
        r = $urandom_range(99);
        lim = (cur_cfg.pay_limit < 8'd8) ? cur_cfg.pay_limit : 8'd8;
        if (r < 10) return cur_cfg.ack_code;
        if (r < 18) return cur_cfg.nack_code;
        if (r < 26) return {8'h00, cur_cfg.pay_limit} + 16'd1;
        if (r < 30) return 16'($urandom);
        if (r < 32) return {8'h00, cur_cfg.pay_limit};
        if (r < 42) return 16'h0000;
        return 16'($urandom_range(0, lim));
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        if (!calm && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 33);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (parse_byte(b, r)) begin
            if (row_typed && r.kind != K_PAYLOAD) begin
                r.kind = row_kind;
                r.command_code = row_cmd;
            end
            parser_out_q.push_back(r);
        end
    endtask

    task automatic wait_idle(input int settle);
        s_valid <= 1'b0;
        do @(posedge aclk); while (parser_out_q.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    // holds the request until taken; the caller lowers cfg_valid after the batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SYNC_FIRST:  cur_cfg.sync_first = d[7:0];
            REG_SYNC_SECOND: cur_cfg.sync_second = d[7:0];
            REG_DIRECTION:   cur_cfg.direction = d[7:0];
            REG_ACK_CODE:    cur_cfg.ack_code = d;
            REG_NACK_CODE:   cur_cfg.nack_code = d;
            REG_PAY_LIMIT:   cur_cfg.pay_limit = d[7:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input cfg_t c);
        write_reg(REG_SYNC_FIRST, {8'($urandom), c.sync_first});
        write_reg(REG_SYNC_SECOND, {8'($urandom), c.sync_second});
        write_reg(REG_DIRECTION, {8'($urandom), c.direction});
        write_reg(REG_ACK_CODE, c.ack_code);
        write_reg(REG_NACK_CODE, c.nack_code);
        write_reg(REG_PAY_LIMIT, {8'($urandom), c.pay_limit});
        write_reg(REG_SPARE_LO, 16'($urandom));
        write_reg(REG_SPARE_HI, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_frame(output int n);
        fault_t            f;
        int                r;
        int                cut;
        logic [SIZE_W-1:0] len;
        if ($urandom_range(24) == 0) wait_idle(0);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
        r = $urandom_range(99);
        f = (r < 70) ? FR_CLEAN : (r < 76) ? FR_SYNC : (r < 82) ? FR_DIR :
            (r < 88) ? FR_HDR : FR_PAY;
        len = pick_len();
        build_frame(f, 8'($urandom), len);
        // broken-off frame: the next one lands mid-parse
        if ($urandom_range(19) == 0 && frame_bytes.size() > 1) begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            repeat (cut) void'(frame_bytes.pop_back());
        end
        n = frame_bytes.size();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    endtask

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (parser_out_q.size() == 0) begin
                $display("%0t: unexpected result, kind %0d payload %0h command %0h",
                         $time, m_kind, m_payload_byte, m_command_code);
                fails++;
            end else begin
                want = parser_out_q.pop_front();
                if (m_kind != want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, m_kind);
                    fails++;
                end
                if (m_payload_byte != want.payload_byte) begin
                    $display("%0t: payload_byte expected %0h actual %0h",
                             $time, want.payload_byte, m_payload_byte);
                    fails++;
                end
                if (m_command_code != want.command_code) begin
                    $display("%0t: command_code expected %0h actual %0h",
                             $time, want.command_code, m_command_code);
                    fails++;
                end
            end
        end
        m_ready <= calm || ($urandom_range(99) >= 33);
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        probe_row_t probe_rows[10];
        cfg_t       settings[5];
        int         sent;
        int         n;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cur_cfg   = '{SYNC_FIRST_RST, SYNC_SECOND_RST, DIRECTION_RST, ACK_CODE_RST,
                      NACK_CODE_RST, PAY_LIMIT_RST};
        cur_phase = PH_SYNC1;
        held_cmd  = '0;
        held_len  = '0;
        run_sum   = '0;
        rx_sum_hi = '0;
        remain    = '0;

        probe_rows = '{
            '{FR_NOISE, 8'h00, 16'h0000,      1'b0, K_PAYLOAD, 8'h00},
            '{FR_SYNC,  8'h00, 16'h0000,      1'b1, K_BADSYNC, 8'h00},
            '{FR_DIR,   8'h00, 16'h0000,      1'b1, K_BADDIR,  8'h00},
            '{FR_HDR,   8'hFF, 16'h0003,      1'b1, K_BADHDR,  8'hFF},
            '{FR_CLEAN, 8'h00, ACK_CODE_RST,  1'b1, K_ACK,     8'h00},
            '{FR_CLEAN, 8'hFF, NACK_CODE_RST, 1'b1, K_NACK,    8'hFF},
            '{FR_CLEAN, 8'h5A, 16'h0100,      1'b1, K_TOOLONG, 8'h5A},
            '{FR_CLEAN, 8'h81, 16'h0000,      1'b1, K_OK,      8'h81},
            '{FR_CLEAN, 8'h3C, 16'h0003,      1'b0, K_OK,      8'h3C},
            '{FR_PAY,   8'h7E, 16'h0001,      1'b1, K_BADPAY,  8'h7E}
        };

        settings[0] = cur_cfg;
        settings[1] = '{8'($urandom), 8'($urandom), 8'($urandom),
                        16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
                        8'($urandom_range(4, 40))};
        settings[2] = '0;
        settings[3] = '1;
        settings[4] = '{8'($urandom), 8'($urandom), 8'($urandom),
                        16'($urandom), 16'($urandom), 8'($urandom)};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values, one frame per row
        foreach (probe_rows[i]) begin
            row_typed = probe_rows[i].typed;
            row_kind  = probe_rows[i].kind;
            row_cmd   = probe_rows[i].kind_cmd;
            build_frame(probe_rows[i].fault, probe_rows[i].cmd, probe_rows[i].len);
            foreach (frame_bytes[j]) send_byte(frame_bytes[j]);
        end
        row_typed = 1'b0;

        foreach (settings[p]) begin
            wait_idle(SETTLE);
            load_config(settings[p]);
            calm = (p == 1);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                send_random_frame(n);
                sent += n;
            end
        end
        calm = 1'b0;

        wait_idle(10);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* radio_response_frame_parser.f */
+incdir+hdl
hdl/rrfp_pkg.sv
hdl/rrfp_core.sv
hdl/radio_response_frame_parser.sv
test/tb.sv
